// File: src/poi_pkg.sv
// Package for the planar odometry integrator: field widths, fixed-point constants,
// the CORDIC arctangent table and the vector fold used before each rotation.
// Depends on nothing; used by the top level and its checker.
package poi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 30;
    localparam int ATAN_IDX_W       = 5;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 176;
    localparam int DB_W       = 15;
    localparam logic [DB_W-1:0] DB_RESET = 15'd123;

    // CORDIC datapath: vector components and residual angle.
    localparam int CW = 34;
    // Shared multiplier operand widths.
    localparam int MA_W = 34;
    localparam int MB_W = 31;
    localparam int MP_W = MA_W + MB_W;

    localparam logic signed [MB_W-1:0] INV_GAIN   = 31'sd39797;
    localparam logic signed [MB_W-1:0] RAD_TO_BAM = 31'sd683565276;

    localparam logic signed [CW-1:0] QUARTER_TURN = 34'sh0_4000_0000;
    localparam logic signed [CW-1:0] HALF_TURN    = 34'sh0_8000_0000;
    localparam logic signed [CW-1:0] UNIT_Q28     = 34'sh0_1000_0000;

    localparam logic signed [15:0] Q14_MAX = 16'sd16384;
    localparam logic signed [15:0] Q14_MIN = -16'sd16384;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } poi_vec_t;

    // atan(2^-i) with a full turn equal to 2^32.
    function automatic logic [29:0] atan_ent(input logic [ATAN_IDX_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000029;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000003;
            5'd29: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    // Bring the angle into plus or minus a quarter turn by negating the vector.
    function automatic poi_vec_t cordic_fold(input logic signed [CW-1:0] x0,
                                             input logic signed [CW-1:0] y0,
                                             input logic [31:0] ang);
        poi_vec_t v;
        v.x = x0;
        v.y = y0;
        v.z = signed'({{(CW-32){ang[31]}}, ang});
        if (v.z > QUARTER_TURN) begin
            v.x = -x0;
            v.y = -y0;
            v.z = v.z - HALF_TURN;
        end else if (v.z < -QUARTER_TURN) begin
            v.x = -x0;
            v.y = -y0;
            v.z = v.z + HALF_TURN;
        end
        return v;
    endfunction

endpackage

// File: src/planar_odometry_integrator.sv
// Planar odometry integrator: dead reckoning of pose from body velocities and yaw rate.
// Each item is accepted only when idle and is worked through two passes of the shared
// CORDIC stage plus eight passes through the one shared multiplier before its result is
// offered; a new item is accepted only after the last result has been registered for output.
// Reset (rst_n low, asynchronous): position and heading go to zero, the deadband to 123.
// Depends on poi_pkg.
module planar_odometry_integrator #(
    parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Deadband register write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [poi_pkg::DB_W-1:0]            cfg_data,
    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // From bit 0: vel_x[15:0], vel_y[31:16], yaw_rate_raw[47:32],
    // vel_interval[63:48], imu_interval[79:64].
    input  logic [poi_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // From bit 0: pos_x[31:0], pos_y[63:32], heading[95:64], quat_z[111:96],
    // quat_w[127:112], yaw_rate_out[143:128], vel_x_out[159:144], vel_y_out[175:160].
    output logic [poi_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import poi_pkg::*;

    // Step counter of the CORDIC; a clog2-wide counter indexes the angle table.
    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    // The sequencer walks through the work of one item:
    //   ROT     - CORDIC iterations (first on the velocity, then on the half heading)
    //   M_XG..  - gain removal, interval scaling and position update on the multiplier
    //   M_RI/RB - yaw rate times interval, then times radians-to-binary-angle
    //   M_HD    - heading update
    //   R2_INIT - set up the second rotation for the quaternion
    //   Q_*     - gain removal and rounding of sin and cos of half the heading
    typedef enum logic [3:0] {
        S_IDLE,
        S_ROT,
        S_M_XG,
        S_M_YG,
        S_M_XV,
        S_M_YV,
        S_M_RI,
        S_M_RB,
        S_M_HD,
        S_R2_INIT,
        S_Q_Z,
        S_Q_W,
        S_Q_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    phase_reg, phase_next;

    logic signed [CW-1:0]    cx_reg, cx_next;
    logic signed [CW-1:0]    cy_reg, cy_next;
    logic signed [CW-1:0]    cz_reg, cz_next;
    logic signed [MP_W-1:0]  prod_reg, prod_next;
    logic signed [31:0]      ax_reg, ax_next;
    logic signed [31:0]      ay_reg, ay_next;

    logic signed [15:0]      vx_reg, vx_next;
    logic signed [15:0]      vy_reg, vy_next;
    logic signed [15:0]      rate_reg, rate_next;
    logic [15:0]             vdt_reg, vdt_next;
    logic [15:0]             idt_reg, idt_next;
    logic signed [15:0]      qz_reg, qz_next;

    logic signed [31:0]      pos_x_reg, pos_x_next;
    logic signed [31:0]      pos_y_reg, pos_y_next;
    logic [31:0]             head_reg, head_next;
    logic [DB_W-1:0]         db_reg, db_next;

    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                    out_valid_reg, out_valid_next;

    // Shared multiplier.
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic                    mul_en;
    logic signed [MP_W-1:0]  mul_full;

    // CORDIC iteration datapath (shared shifters and adders).
    logic signed [CW-1:0]    sh_x, sh_y, atan_ext;
    logic signed [CW-1:0]    it_x, it_y, it_z;

    // Field views of the input item.
    logic signed [15:0]      in_vx, in_vy, in_rate;
    logic signed [16:0]      rate_w, db_w;
    logic                    rate_dead;
    logic signed [15:0]      rate_db;
    poi_vec_t                fold1, fold2;

    // Rounding paths out of the product register.
    logic signed [MP_W-1:0]  pos_rnd, head_rnd, q_rnd;
    logic signed [33:0]      dpos;
    logic [31:0]             dang;
    logic signed [15:0]      q_val;
    logic signed [31:0]      pos_upd;

    logic                    in_fire, out_fire;

    // Saturating add of a position increment to a 32-bit position.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [33:0] d);
        logic signed [34:0] s;
        s = 35'(a) + 35'(d);
        if (s > 35'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -35'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    // Round a gain-scaled product to Q1.14 and clamp to plus or minus one.
    function automatic logic signed [15:0] clamp_q14(input logic signed [MP_W-1:0] r);
        logic signed [MP_W-1:0] t;
        t = r >>> 30;
        if (t > MP_W'(Q14_MAX)) begin
            return Q14_MAX;
        end else if (t < MP_W'(Q14_MIN)) begin
            return Q14_MIN;
        end
        return t[15:0];
    endfunction

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = out_valid_reg && m_axis_tready;

    assign in_vx   = s_axis_tdata[15:0];
    assign in_vy   = s_axis_tdata[31:16];
    assign in_rate = s_axis_tdata[47:32];

    // A rate strictly inside the deadband is forced to zero; the edge itself is kept.
    assign rate_w    = 17'(in_rate);
    assign db_w      = signed'({2'b00, db_reg});
    assign rate_dead = (rate_w > -db_w) && (rate_w < db_w);
    assign rate_db   = rate_dead ? 16'sd0 : in_rate;

    // The velocity is rotated by the heading held before this item.
    assign fold1 = cordic_fold(signed'({{(CW-30){in_vx[15]}}, in_vx, 14'b0}),
                               signed'({{(CW-30){in_vy[15]}}, in_vy, 14'b0}),
                               head_reg);
    // The quaternion comes from half of the updated heading.
    assign fold2 = cordic_fold(UNIT_Q28, '0, {1'b0, head_reg[31:1]});

    // One CORDIC micro-rotation with floor shifts.
    assign sh_x     = cy_reg >>> cnt_reg;
    assign sh_y     = cx_reg >>> cnt_reg;
    assign atan_ext = signed'({{(CW-30){1'b0}}, atan_ent(ATAN_IDX_W'(cnt_reg))});
    always_comb
    begin
        if (!cz_reg[CW-1]) begin
            it_x = cx_reg - sh_x;
            it_y = cy_reg + sh_y;
            it_z = cz_reg - atan_ext;
        end else begin
            it_x = cx_reg + sh_x;
            it_y = cy_reg - sh_y;
            it_z = cz_reg + atan_ext;
        end
    end

    assign mul_full = mul_a * mul_b;

    assign pos_rnd  = prod_reg + (MP_W'(1) <<< 21);
    assign dpos     = 34'(pos_rnd >>> 22);
    assign head_rnd = prod_reg + (MP_W'(1) <<< 23);
    assign dang     = head_rnd[55:24];
    assign q_rnd    = prod_reg + (MP_W'(1) <<< 29);
    assign q_val    = clamp_q14(q_rnd);
    assign pos_upd  = sat_add(phase_reg ? pos_y_reg : pos_x_reg, dpos);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        rate_next      = rate_reg;
        vdt_next       = vdt_reg;
        idt_next       = idt_reg;
        qz_next        = qz_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        head_next      = head_reg;
        db_next        = db_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        mul_a          = '0;
        mul_b          = '0;
        mul_en         = 1'b0;

        if (out_fire) begin
            out_valid_next = 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
            db_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire) begin
                    vx_next    = in_vx;
                    vy_next    = in_vy;
                    rate_next  = rate_db;
                    vdt_next   = s_axis_tdata[63:48];
                    idt_next   = s_axis_tdata[79:64];
                    cx_next    = fold1.x;
                    cy_next    = fold1.y;
                    cz_next    = fold1.z;
                    cnt_next   = '0;
                    phase_next = 1'b0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                cx_next  = it_x;
                cy_next  = it_y;
                cz_next  = it_z;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = phase_reg ? S_Q_Z : S_M_XG;
                end
            end
            S_M_XG:
            begin
                mul_a      = cx_reg;
                mul_b      = INV_GAIN;
                mul_en     = 1'b1;
                state_next = S_M_YG;
            end
            S_M_YG:
            begin
                ax_next    = 32'(prod_reg >>> 16);
                mul_a      = cy_reg;
                mul_b      = INV_GAIN;
                mul_en     = 1'b1;
                state_next = S_M_XV;
            end
            S_M_XV:
            begin
                ay_next    = 32'(prod_reg >>> 16);
                mul_a      = MA_W'(ax_reg);
                mul_b      = signed'({{(MB_W-16){1'b0}}, vdt_reg});
                mul_en     = 1'b1;
                state_next = S_M_YV;
            end
            S_M_YV:
            begin
                // phase_reg is still low here, so pos_upd works on x.
                pos_x_next = pos_upd;
                phase_next = 1'b1;
                mul_a      = MA_W'(ay_reg);
                mul_b      = signed'({{(MB_W-16){1'b0}}, vdt_reg});
                mul_en     = 1'b1;
                state_next = S_M_RI;
            end
            S_M_RI:
            begin
                pos_y_next = pos_upd;
                mul_a      = MA_W'(rate_reg);
                mul_b      = signed'({{(MB_W-16){1'b0}}, idt_reg});
                mul_en     = 1'b1;
                state_next = S_M_RB;
            end
            S_M_RB:
            begin
                // Rate times interval is a signed 33-bit value.
                mul_a      = MA_W'(signed'(prod_reg[32:0]));
                mul_b      = RAD_TO_BAM;
                mul_en     = 1'b1;
                state_next = S_M_HD;
            end
            S_M_HD:
            begin
                head_next  = head_reg + dang;
                state_next = S_R2_INIT;
            end
            S_R2_INIT:
            begin
                cx_next    = fold2.x;
                cy_next    = fold2.y;
                cz_next    = fold2.z;
                cnt_next   = '0;
                state_next = S_ROT;
            end
            S_Q_Z:
            begin
                mul_a      = cy_reg;
                mul_b      = INV_GAIN;
                mul_en     = 1'b1;
                state_next = S_Q_W;
            end
            S_Q_W:
            begin
                qz_next    = q_val;
                mul_a      = cx_reg;
                mul_b      = INV_GAIN;
                mul_en     = 1'b1;
                state_next = S_Q_DONE;
            end
            S_Q_DONE:
            begin
                // Wait here while the previous result has not been taken.
                if (!out_valid_reg || m_axis_tready) begin
                    out_data_next  = {vy_reg, vx_reg, rate_reg, q_val, qz_reg,
                                      head_reg, pos_y_reg, pos_x_reg};
                    out_valid_next = 1'b1;
                    phase_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        prod_next = mul_en ? mul_full : prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            prod_reg      <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            rate_reg      <= '0;
            vdt_reg       <= '0;
            idt_reg       <= '0;
            qz_reg        <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            head_reg      <= '0;
            db_reg        <= DB_RESET;
            out_data_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            cz_reg        <= cz_next;
            prod_reg      <= prod_next;
            ax_reg        <= ax_next;
            ay_reg        <= ay_next;
            vx_reg        <= vx_next;
            vy_reg        <= vy_next;
            rate_reg      <= rate_next;
            vdt_reg       <= vdt_next;
            idt_reg       <= idt_next;
            qz_reg        <= qz_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            head_reg      <= head_next;
            db_reg        <= db_next;
            out_data_reg  <= out_data_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/poi_checker.sv
// Port-level checker for the planar odometry integrator, bound to the top level.
// Depends on poi_pkg for the port widths and the Q1.14 limits.
module poi_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [poi_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import poi_pkg::*;

    // A result that is not taken stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed or dropped while stalled");

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after an item was accepted");

    // No result can come out of the item accepted in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid || $stable(m_axis_tdata))
        else $error("result appeared one cycle after an input item");

    // Quaternion components lie within plus or minus one in Q1.14.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[111:96]) >= Q14_MIN) &&
            ($signed(m_axis_tdata[111:96]) <= Q14_MAX) &&
            ($signed(m_axis_tdata[127:112]) >= Q14_MIN) &&
            ($signed(m_axis_tdata[127:112]) <= Q14_MAX))
        else $error("quaternion component out of range");

    // The deadband register can always be written.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
